[design/msm_pkg.sv]
// ----------------------------------------------------------------------------
// msm_pkg
// Types and constants shared by the matrix slice multiply unit and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned IdxW   = 4;   // row / col fields
  localparam int unsigned ValW   = 16;  // Q7.8 element
  localparam int unsigned ProdW  = 32;  // Q15.16 product
  localparam int unsigned AccW   = 40;  // Q23.16 sum
  localparam int unsigned CfgW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SeqW   = 6;   // step index carried along the chain

  typedef enum logic [CmdW-1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SLICE_ROWS  = 2'd1;

  typedef struct packed {
    cmd_e                   command;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [AccW-1:0] product_value;
    logic [IdxW-1:0]        out_col;
    logic                   last;
    logic                   bad_index;
  } out_t;

  // token handed from cell to cell: one element of the A row
  typedef struct packed {
    logic                   valid;
    logic signed [ValW-1:0] a;
    logic [SeqW-1:0]        j;
  } tok_t;

  // B column store write, broadcast to all cells
  typedef struct packed {
    logic [IdxW-1:0]        row;
    logic signed [ValW-1:0] value;
  } bwr_t;

endpackage

`default_nettype wire

[design/msm_cell.sv]
// ----------------------------------------------------------------------------
// msm_cell
// One column of C: holds a column of B, multiplies the passing A element by
// the matching B entry and accumulates the product; forwards the token.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_cell
  import msm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   clr_i,
  input  wire tok_t                   tok_i,
  output tok_t                        tok_o,
  input  wire logic                   bwr_en_i,
  input  wire bwr_t                   bwr_i,
  output logic signed [AccW-1:0]      acc_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SIDE);

  logic signed [ValW-1:0]  b_mem [MAX_SIDE];
  logic signed [ValW-1:0]  b_rd_q;
  tok_t                    tok_q;
  logic                    prod_v_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (bwr_en_i) begin
      b_mem[IDX_W'(bwr_i.row)] <= bwr_i.value;
    end
    b_rd_q <= b_mem[tok_i.j[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      prod_v_q <= 1'b0;
      prod_q   <= '0;
      acc_q    <= '0;
    end else begin
      tok_q    <= tok_i;
      prod_v_q <= tok_q.valid;
      prod_q   <= tok_q.a * b_rd_q;
      if (clr_i) begin
        acc_q <= '0;
      end else if (prod_v_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

[design/matrix_slice_multiply_unit.sv]
// ----------------------------------------------------------------------------
// matrix_slice_multiply_unit
// Slice of C = A x B over signed Q7.8 elements with exact Q23.16 sums.
// ----------------------------------------------------------------------------
// Write commands for A and B each carry one element. A compute command
// streams the n elements of the A row, one per cycle, down a chain of
// MAX_SIDE cells; cell k holds column k of B and accumulates element k of
// the C row. A compute feeds the row, waits for the last token to cross the
// chain and its multiply-accumulate to settle, then emits the n results of
// the C row, held back while the output is stalled. A bad index gives one
// error beat. No input is taken while a compute is running.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_slice_multiply_unit
  import msm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W     = $clog2(MAX_SIDE);
  localparam int unsigned CNT_W     = $clog2(MAX_SIDE + 1);
  localparam int unsigned DRAIN_LEN = MAX_SIDE + 3;
  localparam int unsigned DRN_W     = $clog2(DRAIN_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FEED,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e                 state_q;
  logic [CfgW-1:0]        matrix_size_q;
  logic [CfgW-1:0]        slice_rows_q;
  logic [IDX_W-1:0]       row_q;
  logic [CNT_W-1:0]       n_q;
  logic [CNT_W-1:0]       j_q;
  logic [CNT_W-1:0]       k_q;
  logic [DRN_W-1:0]       drn_q;
  logic                   clr_q;
  logic                   feed_v_q;
  logic [SeqW-1:0]        feed_j_q;
  logic signed [ValW-1:0] a_rd_q;
  logic                   out_valid_q;
  out_t                   out_q;

  logic signed [ValW-1:0] a_mem [MAX_SIDE][MAX_SIDE];

  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       h_eff;
  logic                   ok_a, ok_b, ok_c;
  logic                   out_free;
  logic                   in_acc;
  out_t                   err_beat;

  tok_t                   tok_w [MAX_SIDE+1];
  logic signed [AccW-1:0] acc_w [MAX_SIDE];
  bwr_t                   bwr;

  // effective sizes: n saturated to [1, MAX_SIDE], height to [1, n]
  always_comb begin
    if (matrix_size_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(matrix_size_q) > int'(MAX_SIDE)) begin
      n_eff = CNT_W'(MAX_SIDE);
    end else begin
      n_eff = CNT_W'(matrix_size_q);
    end
    if (slice_rows_q == '0) begin
      h_eff = CNT_W'(1);
    end else if (int'(slice_rows_q) > int'(n_eff)) begin
      h_eff = n_eff;
    end else begin
      h_eff = CNT_W'(slice_rows_q);
    end
  end

  assign ok_a = (int'(in_data_i.row) < int'(h_eff)) && (int'(in_data_i.col) < int'(n_eff));
  assign ok_b = (int'(in_data_i.row) < int'(n_eff)) && (int'(in_data_i.col) < int'(n_eff));
  assign ok_c = (int'(in_data_i.row) < int'(h_eff));

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign err_beat = '{product_value: '0, out_col: '0, last: 1'b1, bad_index: 1'b1};

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= CfgW'(16);
      slice_rows_q  <= CfgW'(16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MATRIX_SIZE: matrix_size_q <= cfg_data_i;
        REG_SLICE_ROWS:  slice_rows_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A slice store
  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.command == CMD_WR_A && ok_a) begin
      a_mem[IDX_W'(in_data_i.row)][IDX_W'(in_data_i.col)] <= in_data_i.value;
    end
    a_rd_q <= a_mem[row_q][j_q[IDX_W-1:0]];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      n_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drn_q       <= '0;
      clr_q       <= 1'b0;
      feed_v_q    <= 1'b0;
      feed_j_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      clr_q    <= 1'b0;
      feed_v_q <= (state_q == S_FEED);
      feed_j_q <= SeqW'(j_q);
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data_i.command)
              CMD_WR_A: begin
                if (!ok_a) begin
                  out_valid_q <= 1'b1;
                  out_q       <= err_beat;
                end
              end
              CMD_WR_B: begin
                if (!ok_b) begin
                  out_valid_q <= 1'b1;
                  out_q       <= err_beat;
                end
              end
              CMD_COMPUTE: begin
                if (!ok_c) begin
                  out_valid_q <= 1'b1;
                  out_q       <= err_beat;
                end else begin
                  row_q   <= IDX_W'(in_data_i.row);
                  n_q     <= n_eff;
                  j_q     <= '0;
                  clr_q   <= 1'b1;
                  state_q <= S_FEED;
                end
              end
              default: ;
            endcase
          end
        end
        S_FEED: begin
          j_q <= CNT_W'(j_q + 1'b1);
          if (CNT_W'(j_q + 1'b1) == n_q) begin
            drn_q   <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the last token to reach the end of the chain
          if (drn_q == DRN_W'(DRAIN_LEN - 1)) begin
            k_q     <= '0;
            state_q <= S_EMIT;
          end else begin
            drn_q <= DRN_W'(drn_q + 1'b1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_q.product_value <= acc_w[k_q[IDX_W-1:0]];
            out_q.out_col       <= IdxW'(k_q);
            out_q.last          <= (CNT_W'(k_q + 1'b1) == n_q);
            out_q.bad_index     <= 1'b0;
            k_q                 <= CNT_W'(k_q + 1'b1);
            if (CNT_W'(k_q + 1'b1) == n_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // cell chain
  assign tok_w[0] = '{valid: feed_v_q, a: a_rd_q, j: feed_j_q};
  assign bwr      = '{row: in_data_i.row, value: in_data_i.value};

  for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
    logic bwr_en;
    assign bwr_en = in_acc && (in_data_i.command == CMD_WR_B) && ok_b &&
                    (int'(in_data_i.col) == k);
    msm_cell #(
      .MAX_SIDE (MAX_SIDE)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clr_i    (clr_q),
      .tok_i    (tok_w[k]),
      .tok_o    (tok_w[k+1]),
      .bwr_en_i (bwr_en),
      .bwr_i    (bwr),
      .acc_o    (acc_w[k])
    );
  end

  // assertions
  a_err_beat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_index |->
      out_data_o.last && out_data_o.product_value == '0 && out_data_o.out_col == '0)
    else $error("error beat with payload");

  a_feed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FEED |-> j_q < n_q)
    else $error("feed index past row length");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> k_q < n_q && !feed_v_q)
    else $error("emit index out of range or chain not drained");

  a_busy_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FEED |=> !(out_valid_q && out_q.bad_index && !$past(out_valid_q)))
    else $error("error beat raised during compute");

endmodule

`default_nettype wire

[test/matrix_slice_multiply_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_slice_multiply_unit_tb
// Loads A slice and B elements, issues row computes under several size
// settings and checks every C element beat, in order, against a row
// predictor kept in the bench. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module matrix_slice_multiply_unit_tb;
  import msm_pkg::*;

  localparam int unsigned SIDE = 16;
  localparam logic [CmdW-1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;

  // predicted C row elements, plus a mirror of both element stores
  class c_row_tracker;
    logic signed [ValW-1:0] a_elem [SIDE][SIDE];
    logic signed [ValW-1:0] b_elem [SIDE][SIDE];
    bit a_set [SIDE][SIDE];
    bit b_set [SIDE][SIDE];
    logic [CfgW-1:0] size_reg = 5'd16;
    logic [CfgW-1:0] rows_reg = 5'd16;
    out_t c_elems_due[$];
    int fails = 0;

    function int side();
      if (size_reg < 1) return 1;
      if (size_reg > SIDE) return SIDE;
      return int'(size_reg);
    endfunction

    function int height();
      int n;
      n = side();
      if (rows_reg < 1) return 1;
      if (rows_reg > n) return n;
      return int'(rows_reg);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_MATRIX_SIZE: size_reg = data;
        REG_SLICE_ROWS: rows_reg = data;
        default: ;
      endcase
    endfunction

    // entries still unwritten that a compute of row r would read
    function void list_gaps(int r, output int gaps[$]);
      int n;
      n = side();
      gaps.delete();
      for (int j = 0; j < n; j++)
        if (!a_set[r][j]) gaps.push_back((r << 4) | j);
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++)
          if (!b_set[j][k]) gaps.push_back(256 | (j << 4) | k);
    endfunction

    function void push_error();
      out_t e;
      e = '0;
      e.last = 1'b1;
      e.bad_index = 1'b1;
      c_elems_due.push_back(e);
    endfunction

    function void take_command(in_t it);
      int n, h;
      longint acc;
      out_t e;
      n = side();
      h = height();
      case (it.command)
        CMD_WR_A: begin
          if (it.row >= h || it.col >= n) begin
            push_error();
          end else begin
            a_elem[it.row][it.col] = it.value;
            a_set[it.row][it.col] = 1'b1;
          end
        end
        CMD_WR_B: begin
          if (it.row >= n || it.col >= n) begin
            push_error();
          end else begin
            b_elem[it.row][it.col] = it.value;
            b_set[it.row][it.col] = 1'b1;
          end
        end
        CMD_COMPUTE: begin
          if (it.row >= h) begin
            push_error();
          end else begin
            for (int k = 0; k < n; k++) begin
              acc = 0;
              for (int j = 0; j < n; j++)
                acc += longint'(a_elem[it.row][j]) * longint'(b_elem[j][k]);
              e.product_value = AccW'(acc);
              e.out_col = IdxW'(k);
              e.last = (k == n - 1);
              e.bad_index = 1'b0;
              c_elems_due.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_elem(out_t got);
      out_t want;
      if (c_elems_due.size() == 0) begin
        $error("unexpected beat: out_col %0d product_value %0d",
               got.out_col, got.product_value);
        fails++;
        return;
      end
      want = c_elems_due.pop_front();
      if (got.product_value !== want.product_value) begin
        $error("product_value: expected %0d, got %0d", want.product_value,
               got.product_value);
        fails++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fails++;
      end
      if (got.bad_index !== want.bad_index) begin
        $error("bad_index: expected %0d, got %0d", want.bad_index, got.bad_index);
        fails++;
      end
    endfunction

    function int pending();
      return c_elems_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  c_row_tracker c_rows;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int cycle_cnt = 0;

  int phase_size[6]  = '{0, 3, 6, 16, 31, 9};
  int phase_rows[6]  = '{31, 2, 6, 1, 0, 12};
  int phase_items[6] = '{20, 40, 50, 140, 20, 30};

  matrix_slice_multiply_unit #(
    .MAX_SIDE(SIDE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** matrix_slice_multiply_unit: FAILED **");
      $finish;
    end
  end

  // result side: sample at the rising edge, decide stall at the falling edge
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) c_rows.check_elem(out_data_o);
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic logic signed [ValW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return ValW'($urandom);
    endcase
  endfunction

  function automatic in_t elem_cmd(logic [CmdW-1:0] c, int r, int k, int v);
    in_t it;
    it.command = cmd_e'(c);
    it.row = IdxW'(r);
    it.col = IdxW'(k);
    it.value = ValW'(v);
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_stall_o);
    c_rows.take_command(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = CfgW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    c_rows.set_reg(idx, cfg_data_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait for every predicted beat, then let a late error beat surface
  task automatic settle();
    in_valid_i = 1'b0;
    while (c_rows.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly fill what a chosen row needs, then compute it; a little noise
  task automatic pick_command(output in_t it);
    int roll, r, n, h, g;
    int gaps[$];
    n = c_rows.side();
    h = c_rows.height();
    roll = $urandom_range(0, 99);
    it.command = cmd_e'(CMD_NONE);
    it.row = IdxW'($urandom);
    it.col = IdxW'($urandom);
    it.value = rand_value();
    if (roll < 4) begin
      // unused opcode, left as is
    end else if (roll < 10) begin
      it.command = cmd_e'(CmdW'($urandom_range(0, 2)));
      c_rows.list_gaps(it.row, gaps);
      if (it.command == CMD_COMPUTE && it.row < h && gaps.size() != 0)
        it.command = CMD_WR_B;
    end else begin
      r = $urandom_range(0, h - 1);
      c_rows.list_gaps(r, gaps);
      if (gaps.size() != 0) begin
        g = gaps[$urandom_range(0, gaps.size() - 1)];
        it.command = g[8] ? CMD_WR_B : CMD_WR_A;
        it.row = g[7:4];
        it.col = g[3:0];
      end else if (roll < 45) begin
        it.command = CMD_COMPUTE;
        it.row = IdxW'(r);
      end else if (roll[0]) begin
        it.command = CMD_WR_A;
        it.row = IdxW'($urandom_range(0, h - 1));
        it.col = IdxW'($urandom_range(0, n - 1));
      end else begin
        it.command = CMD_WR_B;
        it.row = IdxW'($urandom_range(0, n - 1));
        it.col = IdxW'($urandom_range(0, n - 1));
      end
    end
  endtask

  initial begin
    in_t it;
    in_t opening[$];
    int sent;
    c_rows = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MATRIX_SIZE;
    cfg_data_i = '0;
    send_idle_pct = 8;
    stall_pct = 57;
    hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sizes still at reset: corner entries and the unused opcode
    send_item(elem_cmd(CMD_WR_A, 15, 15, 32767));
    send_item(elem_cmd(CMD_WR_B, 15, 15, -32768));
    send_item(elem_cmd(CMD_NONE, 15, 15, -1));
    settle();

    write_reg(REG_MATRIX_SIZE, 2);
    write_reg(REG_SLICE_ROWS, 2);
    opening.push_back(elem_cmd(CMD_WR_A, 0, 0, -32768));
    opening.push_back(elem_cmd(CMD_WR_A, 0, 1, -32768));
    opening.push_back(elem_cmd(CMD_WR_A, 1, 0, 32767));
    opening.push_back(elem_cmd(CMD_WR_A, 1, 1, 256));
    opening.push_back(elem_cmd(CMD_WR_B, 0, 0, -32768));
    opening.push_back(elem_cmd(CMD_WR_B, 1, 0, -32768));
    opening.push_back(elem_cmd(CMD_WR_B, 0, 1, 32767));
    opening.push_back(elem_cmd(CMD_WR_B, 1, 1, -1));
    opening.push_back(elem_cmd(CMD_COMPUTE, 0, 15, 32767));
    opening.push_back(elem_cmd(CMD_COMPUTE, 1, 0, -1));
    // out of range on each kind of command
    opening.push_back(elem_cmd(CMD_WR_A, 2, 0, 1));
    opening.push_back(elem_cmd(CMD_WR_A, 0, 2, 1));
    opening.push_back(elem_cmd(CMD_WR_B, 2, 1, 1));
    opening.push_back(elem_cmd(CMD_WR_B, 1, 15, 1));
    opening.push_back(elem_cmd(CMD_COMPUTE, 15, 0, 0));
    opening.push_back(elem_cmd(CMD_NONE, 0, 0, 0));
    // rewrite one entry and recompute
    opening.push_back(elem_cmd(CMD_WR_B, 0, 0, 0));
    opening.push_back(elem_cmd(CMD_COMPUTE, 0, 0, 0));
    foreach (opening[i]) send_item(opening[i]);
    settle();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 8 : (p < 4) ? 57 : 0;
      stall_pct = (p < 2) ? 57 : (p < 4) ? 8 : 0;
      write_reg(REG_MATRIX_SIZE, phase_size[p]);
      write_reg(REG_SLICE_ROWS, phase_rows[p]);
      // long output hold-off so the input side backs up
      if (p == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < phase_items[p]) begin
        pick_command(it);
        send_item(it);
        if (it.command != CMD_NONE) sent++;
      end
      settle();
    end

    if (c_rows.fails == 0 && c_rows.pending() == 0) begin
      $display("** matrix_slice_multiply_unit: PASSED **");
    end else begin
      $display("** matrix_slice_multiply_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
design/msm_pkg.sv
design/msm_cell.sv
design/matrix_slice_multiply_unit.sv
test/matrix_slice_multiply_unit_tb.sv
